FILE: src/sector_image_xor_verifier_core_macros.svh
// Assertion helpers for the checker in sivx_checker.sv.
`ifndef SECTOR_IMAGE_XOR_VERIFIER_CORE_MACROS_SVH
`define SECTOR_IMAGE_XOR_VERIFIER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SIVX_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sivx assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SIVX_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sivx assertion failed");

`endif

FILE: src/sivx_pkg.sv
// ----------------------------------------------------------------------------
// sivx_pkg
// Types and constants for the sector image XOR checksum verifier.
// ----------------------------------------------------------------------------
package sivx_pkg;

	localparam logic [15:0] HEADER_BYTES = 16'd6;
	localparam logic [15:0] COUNT_LO_POS = 16'd4;
	localparam logic [15:0] COUNT_HI_POS = 16'd5;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_SIZE   = 3'd2;
	localparam logic [2:0] PH_ADDR   = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_CSUM   = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	localparam logic ST_PASS     = 1'b0;
	localparam logic ST_MISMATCH = 1'b1;

	typedef struct packed {
		logic [7:0] image_byte;
		logic       image_start;
	} image_t;

	typedef struct packed {
		logic        status;
		logic [15:0] failed_sector;
		logic [15:0] sectors_checked;
	} result_t;

endpackage

FILE: src/sector_image_xor_verifier_core.sv
// ----------------------------------------------------------------------------
// sector_image_xor_verifier_core
// Verifies the per-sector XOR checksums of a program image streamed bytewise.
// Throughput: one image byte per cycle; the input stalls only while a result
// is held in the output register and the output side stalls.
// Latency: a result is valid the cycle after the byte that completes it.
// Reset: arst_n clears parse state to idle and empties the result register.
// ----------------------------------------------------------------------------
module sector_image_xor_verifier_core
	import sivx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    image_valid,
	output logic    image_stall,
	input  image_t  image,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic    accept;
	logic    emit;
	result_t res;
	logic    result_valid_q;
	result_t result_q;

	assign image_stall = result_valid_q & result_stall;
	assign accept      = image_valid & ~image_stall;

	sivx_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (image),
		.emit   (emit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: src/sivx_parse.sv
// ----------------------------------------------------------------------------
// sivx_parse
// Image parser: header, per-sector fields and running XOR checksum.
// ----------------------------------------------------------------------------
module sivx_parse
	import sivx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  image_t  item,
	output logic    emit,
	output result_t res
);

	logic [2:0]  phase_q;
	logic [15:0] byte_count_q;
	logic [15:0] sectors_left_q;
	logic [15:0] sector_number_q;
	logic [15:0] sector_length_q;
	logic [15:0] running_sum_q;
	logic [7:0]  low_byte_hold_q;

	logic [2:0]  phase_d;
	logic [15:0] byte_count_d;
	logic [15:0] sectors_left_d;
	logic [15:0] sector_number_d;
	logic [15:0] sector_length_d;
	logic [15:0] running_sum_d;
	logic [7:0]  low_byte_hold_d;

	always_comb begin
		logic [7:0]  b;
		logic [15:0] word;
		logic [15:0] bc_inc;
		b               = item.image_byte;
		phase_d         = phase_q;
		byte_count_d    = byte_count_q;
		sectors_left_d  = sectors_left_q;
		sector_number_d = sector_number_q;
		sector_length_d = sector_length_q;
		running_sum_d   = running_sum_q;
		low_byte_hold_d = low_byte_hold_q;
		emit            = 1'b0;
		res             = '0;

		if (item.image_start) begin
			phase_d         = PH_HEADER;
			byte_count_d    = '0;
			sectors_left_d  = '0;
			sector_number_d = '0;
			sector_length_d = '0;
			running_sum_d   = '0;
			low_byte_hold_d = '0;
		end

		word   = {b, low_byte_hold_d};
		bc_inc = byte_count_d + 16'd1;

		case (phase_d)
			PH_HEADER: begin
				if (byte_count_d == COUNT_LO_POS)
					sectors_left_d = {8'd0, b};
				else if (byte_count_d == COUNT_HI_POS)
					sectors_left_d = {b, sectors_left_d[7:0]};
				byte_count_d = bc_inc;
				if (bc_inc >= HEADER_BYTES) begin
					byte_count_d = '0;
					if (sectors_left_d == '0) begin
						emit                = 1'b1;
						res.status          = ST_PASS;
						res.sectors_checked = sector_number_d;
						phase_d             = PH_DONE;
					end else begin
						phase_d = PH_SIZE;
					end
				end
			end
			PH_SIZE, PH_ADDR, PH_CSUM: begin
				if (byte_count_d == '0) begin
					low_byte_hold_d = b;
					byte_count_d    = 16'd1;
				end else begin
					byte_count_d = '0;
					if (phase_d == PH_SIZE) begin
						sector_length_d = word;
						running_sum_d   = word;
						phase_d         = PH_ADDR;
					end else if (phase_d == PH_ADDR) begin
						running_sum_d = running_sum_d ^ word;
						phase_d = (sector_length_d == '0) ? PH_CSUM : PH_DATA;
					end else if (word != running_sum_d) begin
						emit                = 1'b1;
						res.status          = ST_MISMATCH;
						res.failed_sector   = sector_number_d;
						res.sectors_checked = sector_number_d;
						phase_d             = PH_DONE;
					end else begin
						sector_number_d = sector_number_d + 16'd1;
						sectors_left_d  = sectors_left_d - 16'd1;
						if (sectors_left_d == '0) begin
							emit                = 1'b1;
							res.status          = ST_PASS;
							res.sectors_checked = sector_number_d;
							phase_d             = PH_DONE;
						end else begin
							phase_d = PH_SIZE;
						end
					end
				end
			end
			PH_DATA: begin
				if (!byte_count_d[0]) begin
					low_byte_hold_d = b;
					if ({1'b0, byte_count_d} + 17'd1 == {1'b0, sector_length_d})
						running_sum_d = running_sum_d ^ {8'd0, b};
				end else begin
					running_sum_d = running_sum_d ^ {b, low_byte_hold_q};
				end
				byte_count_d = bc_inc;
				if (bc_inc == sector_length_d) begin
					byte_count_d = '0;
					phase_d      = PH_CSUM;
				end
			end
			default: ;
		endcase

		if (!accept)
			emit = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			byte_count_q    <= '0;
			sectors_left_q  <= '0;
			sector_number_q <= '0;
			sector_length_q <= '0;
			running_sum_q   <= '0;
			low_byte_hold_q <= '0;
		end else if (accept) begin
			phase_q         <= phase_d;
			byte_count_q    <= byte_count_d;
			sectors_left_q  <= sectors_left_d;
			sector_number_q <= sector_number_d;
			sector_length_q <= sector_length_d;
			running_sum_q   <= running_sum_d;
			low_byte_hold_q <= low_byte_hold_d;
		end
	end

endmodule

FILE: src/sivx_checker.sv
// ----------------------------------------------------------------------------
// sivx_checker
// Port-level checks on the verifier core, bound to the top level.
// ----------------------------------------------------------------------------
`include "sector_image_xor_verifier_core_macros.svh"

module sivx_checker
	import sivx_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    image_valid,
	input logic    image_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	`SIVX_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
	`SIVX_ASSERT_IMP(a_stall_cause, image_stall, result_valid && result_stall)
	`SIVX_ASSERT_IMP(a_pass_zero, result_valid && result.status == ST_PASS, result.failed_sector == 16'd0)
	`SIVX_ASSERT_NXT(a_new_result, result_valid && !result_stall, !result_valid || $past(image_valid && !image_stall))

endmodule

bind sector_image_xor_verifier_core sivx_checker u_sivx_checker (.*);
